>>> rtl/core/xtea_block_cipher_unit_defines.svh
// assertion macros for the xtea block cipher unit
// expects clk and arst_n in the scope of the module that uses them
`ifndef XTEA_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define XTEA_BLOCK_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define XBC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xtea unit: same-cycle check failed");

// next-cycle implication, checked out of reset
`define XBC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xtea unit: next-cycle check failed");

`endif

>>> rtl/core/xtea_pkg.sv
// shared types, constants and constant functions of the xtea cipher unit
// no dependencies
`default_nettype none

package xtea_pkg;

	localparam int CYCLES = 32;
	localparam int NHALF = 2 * CYCLES;
	localparam logic [31:0] DELTA = 32'h9E37_79B9;
	localparam int WORD_W = 32;
	localparam int KEY_WORDS = 4;
	localparam int KSEL_W = $clog2(KEY_WORDS);
	localparam int CFG_IDX_W = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 2'd3;

	// operation codes
	localparam logic KIND_ENCRYPT = 1'b0;
	localparam logic KIND_DECRYPT = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] block_first;
		logic [WORD_W-1:0] block_second;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_first;
		logic [WORD_W-1:0] result_second;
	} out_item_t;

	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

	// n times delta, mod 2^32, folded at elaboration
	function automatic logic [WORD_W-1:0] delta_times(input int n);
		logic [WORD_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < NHALF; i++) begin
			if (i < n) acc = acc + DELTA;
		end
		return acc;
	endfunction

	// running sum used by half-round h of an encryption
	function automatic logic [WORD_W-1:0] enc_sum(input int h);
		return (h % 2 == 0) ? delta_times(h / 2) : delta_times(h / 2 + 1);
	endfunction

	// running sum used by half-round h of a decryption
	function automatic logic [WORD_W-1:0] dec_sum(input int h);
		return (h % 2 == 0) ? delta_times(CYCLES - h / 2) : delta_times(CYCLES - h / 2 - 1);
	endfunction

	// key word code: low bits of the sum or bits 12:11
	function automatic logic [KSEL_W-1:0] key_sel(input logic [WORD_W-1:0] s,
		input logic use_high);
		return use_high ? s[12:11] : s[KSEL_W-1:0];
	endfunction

	// xtea mixing term, sum plus key supplied precomputed
	function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v,
		input logic [WORD_W-1:0] sk);
		logic [WORD_W-1:0] sh;
		sh = (v << 4) ^ (v >> 5);
		return (sh + v) ^ sk;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/xtea_block_cipher_unit.sv
// xtea block cipher unit: key registers, half-round pipeline and output skid
// depends on xtea_pkg and xtea_block_cipher_unit_defines.svh
`default_nettype none
`include "xtea_block_cipher_unit_defines.svh"

// Encrypts or decrypts one 64-bit XTEA block per beat under the 128-bit key held
// in configuration registers 0..3 (write the key only while the unit is empty).
// The datapath is a pipeline of one input register, 2*CYCLES = 64 half-round
// stages and an output register, and one block per cycle is sustained while
// the consumer does not stall. A two-entry output buffer keeps the pipeline
// moving one more beat when the consumer stalls; in_stall rises only once
// that buffer is full, and the config port is always ready.
module xtea_block_cipher_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  xtea_pkg::in_item_t            in_data,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output xtea_pkg::out_item_t                 out_data,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [xtea_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [xtea_pkg::WORD_W-1:0]         cfg_data
);

	localparam int NH = xtea_pkg::NHALF;

	xtea_pkg::key_t key_q;

	logic [NH:0]                 valid_s;
	logic                        kind_s [NH+1];
	logic [xtea_pkg::WORD_W-1:0] a_s    [NH+1];
	logic [xtea_pkg::WORD_W-1:0] b_s    [NH+1];
	logic [xtea_pkg::WORD_W-1:0] nxt_a  [NH];
	logic [xtea_pkg::WORD_W-1:0] nxt_b  [NH];

	logic                out_valid_q;
	logic                skid_valid_q;
	xtea_pkg::out_item_t out_data_q;
	xtea_pkg::out_item_t skid_data_q;

	logic                adv;
	logic                in_accept;
	logic                out_take;
	xtea_pkg::out_item_t last_item;

	assign cfg_ready = 1'b1;
	assign adv       = !skid_valid_q;
	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !skid_valid_q;
	assign out_take  = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign last_item.result_first  = a_s[NH];
	assign last_item.result_second = b_s[NH];

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				xtea_pkg::REG_KEY_WORD_0: key_q[0] <= cfg_data;
				xtea_pkg::REG_KEY_WORD_1: key_q[1] <= cfg_data;
				xtea_pkg::REG_KEY_WORD_2: key_q[2] <= cfg_data;
				xtea_pkg::REG_KEY_WORD_3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// half-round datapath, one stage per half-round
	for (genvar h = 0; h < NH; h++) begin : g_half
		localparam logic [xtea_pkg::WORD_W-1:0] ENC_SUM = xtea_pkg::enc_sum(h);
		localparam logic [xtea_pkg::WORD_W-1:0] DEC_SUM = xtea_pkg::dec_sum(h);
		// encrypt uses low sum bits on the first word, decrypt mirrors it
		localparam logic [xtea_pkg::KSEL_W-1:0] ENC_KSEL =
			xtea_pkg::key_sel(ENC_SUM, (h % 2) == 1);
		localparam logic [xtea_pkg::KSEL_W-1:0] DEC_KSEL =
			xtea_pkg::key_sel(DEC_SUM, (h % 2) == 0);

		logic                        dec;
		logic [xtea_pkg::WORD_W-1:0] sk;
		logic [xtea_pkg::WORD_W-1:0] m;

		assign dec = (kind_s[h] == xtea_pkg::KIND_DECRYPT);
		assign sk  = dec ? (DEC_SUM + key_q[DEC_KSEL]) : (ENC_SUM + key_q[ENC_KSEL]);

		if ((h % 2) == 0) begin : g_even
			// encrypt updates the first word, decrypt undoes the second
			assign m     = xtea_pkg::mix(dec ? a_s[h] : b_s[h], sk);
			assign nxt_a[h] = dec ? a_s[h] : (a_s[h] + m);
			assign nxt_b[h] = dec ? (b_s[h] - m) : b_s[h];
		end else begin : g_odd
			// encrypt updates the second word, decrypt undoes the first
			assign m     = xtea_pkg::mix(dec ? b_s[h] : a_s[h], sk);
			assign nxt_a[h] = dec ? (a_s[h] - m) : a_s[h];
			assign nxt_b[h] = dec ? b_s[h] : (b_s[h] + m);
		end
	end

	// stage valid bits, all stages advance together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[NH-1:0], in_accept};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s[0] <= in_data.kind;
			a_s[0]    <= in_data.block_first;
			b_s[0]    <= in_data.block_second;
			for (int i = 0; i < NH; i++) begin
				kind_s[i+1] <= kind_s[i];
				a_s[i+1]    <= nxt_a[i];
				b_s[i+1]    <= nxt_b[i];
			end
		end
	end

	// output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) skid_valid_q <= 1'b0;
		end else if (valid_s[NH]) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register and skid payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) out_data_q <= skid_data_q;
		end else if (valid_s[NH]) begin
			if (!out_valid_q || out_take) begin
				out_data_q <= last_item;
			end else begin
				skid_data_q <= last_item;
			end
		end
	end

	// checks
	`XBC_ASSERT_NOW(a_skid_needs_out, skid_valid_q, out_valid_q)
	`XBC_ASSERT_NEXT(a_skid_holds, skid_valid_q && out_stall, skid_valid_q)
	`XBC_ASSERT_NEXT(a_skid_catches, valid_s[NH] && out_valid_q && out_stall, skid_valid_q)
	`XBC_ASSERT_NEXT(a_pipe_frozen, skid_valid_q, $stable(valid_s))

endmodule

`default_nettype wire
